// ----- src/lirs_pkg.sv -----
package lirs_pkg;

  typedef struct packed {
    logic accept;
    logic first;
    logic wrap;
    logic mul;
    logic emit_interp;
    logic emit_tail;
    logic emit_mark;
    logic clear;
  } lirs_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic pos_lt_one;
    logic sum_ge_one;
    logic out_free;
  } lirs_sts_t;

endpackage

// ----- src/linear_interp_resampler.sv -----
// Per interpolated result an item steps through check, multiply and round-and-emit
//   (S_INTERP_CHK, S_MUL, S_EMIT_I), using the one multiplier; a final item then gives
//   its tail results (S_TAIL_CHK, S_EMIT_T), or only the end marker (S_EMIT_M).
// Output stalls hold the emit states; in_stall stays high until the item is done, and an
//   item that gives no result ends after its check.
// Reset (synchronous, rst_n low): stream state cleared, rate_step back to 1.0.
module linear_interp_resampler #(
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [FRAC_BITS+4:0]          cfg_rate_step,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_carries_sample,
  output logic                          out_end_of_stream
);
  import lirs_pkg::*;

  lirs_cmd_t cmd;
  lirs_sts_t sts;

  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lirs_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_rate_step      (cfg_rate_step),
    .in_sample          (in_sample),
    .in_last_sample     (in_last_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (out_sample),
    .out_carries_sample (out_carries_sample),
    .out_end_of_stream  (out_end_of_stream),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// ----- src/lirs_ctrl.sv -----
module lirs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lirs_pkg::lirs_sts_t  sts,
  output lirs_pkg::lirs_cmd_t  cmd
);
  import lirs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INTERP_CHK,
    S_MUL,
    S_EMIT_I,
    S_TAIL_CHK,
    S_EMIT_T,
    S_EMIT_M
  } state_t;

  state_t state_r, state_nxt;
  logic   any_r, any_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    any_nxt   = any_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          any_nxt    = 1'b0;
          state_nxt  = S_INTERP_CHK;
        end
      end
      S_INTERP_CHK: begin
        if (!sts.have_prev) begin
          cmd.first = 1'b1;
          state_nxt = sts.last ? S_TAIL_CHK : S_IDLE;
        end else if (sts.pos_lt_one) begin
          state_nxt = S_MUL;
        end else begin
          cmd.wrap  = 1'b1;
          state_nxt = sts.last ? S_TAIL_CHK : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT_I;
      end
      S_EMIT_I: begin
        if (sts.out_free) begin
          cmd.emit_interp = 1'b1;
          any_nxt         = 1'b1;
          state_nxt       = S_INTERP_CHK;
        end
      end
      S_TAIL_CHK: begin
        if (sts.pos_lt_one) begin
          state_nxt = S_EMIT_T;
        end else if (any_r) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_M;
        end
      end
      S_EMIT_T: begin
        if (sts.out_free) begin
          cmd.emit_tail = 1'b1;
          any_nxt       = 1'b1;
          if (sts.sum_ge_one) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT_M: begin
        if (sts.out_free) begin
          cmd.emit_mark = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      any_r   <= any_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.first, cmd.wrap, cmd.mul,
              cmd.emit_interp | cmd.emit_tail | cmd.emit_mark}))
    else $error("controller issued conflicting commands");

  a_mark_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_mark |-> !any_r)
    else $error("end marker issued after a sample result");

  a_interp_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_interp |-> sts.have_prev)
    else $error("interpolation without a previous sample");
`endif

endmodule

// ----- src/lirs_dp.sv -----
module lirs_dp #(
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [FRAC_BITS+4:0]          cfg_rate_step,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_carries_sample,
  output logic                          out_end_of_stream,
  input  lirs_pkg::lirs_cmd_t           cmd,
  output lirs_pkg::lirs_sts_t           sts
);
  import lirs_pkg::*;

  localparam int STEP_W = FRAC_BITS + 5;
  localparam int POS_W  = STEP_W + 1;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int Q_W    = PROD_W + 1 - FRAC_BITS;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1) << (FRAC_BITS - 4);
  localparam logic [POS_W-1:0]  ONE        = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0]  TWO        = POS_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [PROD_W:0] HALF  = (PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic [STEP_W-1:0]             step_r;
  logic [STEP_W-1:0]             step_eff;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [POS_W-1:0]              sum;
  logic                          have_prev_r, have_prev_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic                          last_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [PROD_W:0]        rounded;
  logic signed [Q_W-1:0]         q;
  logic signed [Q_W-1:0]         interp_wide;
  logic signed [SAMPLE_BITS-1:0] interp;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_carries_r;
  logic                          out_eos_r;
  logic                          emit_any;

  assign cfg_ready = 1'b1;

  assign step_eff = (step_r < STEP_MIN) ? STEP_MIN : step_r;
  assign sum      = pos_r + POS_W'(step_eff);

  assign diff        = DIFF_W'(cur_r) - DIFF_W'(prev_r);
  assign rounded     = (PROD_W+1)'(prod_r) + HALF;
  assign q           = Q_W'(rounded >>> FRAC_BITS);
  assign interp_wide = Q_W'(prev_r) + q;
  assign interp      = interp_wide[SAMPLE_BITS-1:0];

  assign emit_any = cmd.emit_interp | cmd.emit_tail | cmd.emit_mark;

  assign sts.have_prev  = have_prev_r;
  assign sts.last       = last_r;
  assign sts.pos_lt_one = (pos_r < ONE);
  assign sts.sum_ge_one = (sum >= ONE);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_sample         = out_sample_r;
  assign out_carries_sample = out_carries_r;
  assign out_end_of_stream  = out_eos_r;

  always_comb begin
    pos_nxt       = pos_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    if (cmd.clear) begin
      pos_nxt       = '0;
      have_prev_nxt = 1'b0;
      prev_nxt      = '0;
    end else if (cmd.first) begin
      pos_nxt       = '0;
      have_prev_nxt = 1'b1;
      prev_nxt      = cur_r;
    end else if (cmd.wrap) begin
      pos_nxt  = pos_r - ONE;
      prev_nxt = cur_r;
    end else if (cmd.emit_interp || cmd.emit_tail) begin
      pos_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      pos_r       <= '0;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        step_r <= cfg_rate_step;
      end
      pos_r       <= pos_nxt;
      have_prev_r <= have_prev_nxt;
      prev_r      <= prev_nxt;
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r  <= in_sample;
      last_r <= in_last_sample;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff * $signed({1'b0, pos_r[FRAC_BITS-1:0]}));
    end
    if (cmd.emit_interp) begin
      out_sample_r  <= interp;
      out_carries_r <= 1'b1;
      out_eos_r     <= last_r && (sum >= TWO);
    end else if (cmd.emit_tail) begin
      out_sample_r  <= cur_r;
      out_carries_r <= 1'b1;
      out_eos_r     <= (sum >= ONE);
    end else if (cmd.emit_mark) begin
      out_sample_r  <= '0;
      out_carries_r <= 1'b0;
      out_eos_r     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_any |-> (!out_valid_r || !out_stall))
    else $error("result overwrote a pending request");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (pos_r == '0) && !have_prev_r)
    else $error("stream state not cleared");

  a_marker_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_carries_r) |-> out_eos_r)
    else $error("marker-only result without end of stream");
`endif

endmodule
